[rtl/sida_pkg.sv]
package sida_pkg;

  localparam int ValueW       = 32;
  localparam int NumDigits    = 10;
  localparam int DigitW       = 4;
  localparam int BcdW         = NumDigits * DigitW;
  localparam int BitsPerStage = 4;
  localparam int NumStages    = ValueW / BitsPerStage;
  localparam int IdxW         = 4;
  localparam int CharW        = 8;

  localparam logic [IdxW-1:0]  LastIdx    = IdxW'(NumDigits - 1);
  localparam logic [CharW-1:0] AsciiZero  = 8'd48;
  localparam logic [CharW-1:0] AsciiMinus = 8'd45;

  // One converted number: sign, ten BCD digits (most significant at the top)
  // and the index of the first digit to be shown.
  typedef struct packed {
    logic            neg;
    logic [BcdW-1:0] bcd;
    logic [IdxW-1:0] first;
  } digits_t;

  // One shift-and-add-three step: correct every digit of five or more, then
  // shift the next binary bit in at the bottom.
  function automatic logic [BcdW-1:0] dabble_bit(input logic [BcdW-1:0] bcd,
                                                 input logic            b);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int d = 0; d < NumDigits; d++) begin
      if (adj[d*DigitW +: DigitW] >= 4'd5) begin
        adj[d*DigitW +: DigitW] = adj[d*DigitW +: DigitW] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], b};
  endfunction

  function automatic logic [BcdW-1:0] dabble_group(
      input logic [BcdW-1:0]         bcd,
      input logic [BitsPerStage-1:0] bits);
    logic [BcdW-1:0] acc;
    acc = bcd;
    for (int k = BitsPerStage - 1; k >= 0; k--) begin
      acc = dabble_bit(acc, bits[k]);
    end
    return acc;
  endfunction

  // Digit index 0 is the most significant position.
  function automatic logic [DigitW-1:0] digit_at(input logic [BcdW-1:0] bcd,
                                                 input logic [IdxW-1:0] idx);
    logic [DigitW-1:0] dig;
    dig = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (idx == IdxW'(i)) begin
        dig = bcd[BcdW-1-i*DigitW -: DigitW];
      end
    end
    return dig;
  endfunction

  // First nonzero digit; the units digit is always shown.
  function automatic logic [IdxW-1:0] first_digit(input logic [BcdW-1:0] bcd);
    logic [IdxW-1:0] first;
    first = LastIdx;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      if (digit_at(bcd, IdxW'(i)) != '0) begin
        first = IdxW'(i);
      end
    end
    return first;
  endfunction

endpackage

[rtl/signed_int_to_decimal_ascii.sv]
// Channel   Ports                              Direction  Moves
// value     value_valid, value_stall, value    in         one 32-bit signed request
// char      char_valid, char_stall,            out        one ASCII character
//           ascii_char, last_char
//
// A request passes through the BCD pipeline and the serialiser to the output
// register and leaves as one to eleven characters, one per cycle while
// char_stall is low; the output port therefore sets the sustained request
// rate. Up to twelve requests are held in flight in the BCD pipeline and the
// serialiser. Reset clears every valid bit. A stall on the output holds the
// character in place and backs up through the pipeline, filling empty stages
// before value_stall is raised.
module signed_int_to_decimal_ascii (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               value_valid,
  output logic                               value_stall,
  input  logic signed [sida_pkg::ValueW-1:0] value,
  output logic                               char_valid,
  input  logic                               char_stall,
  output logic [sida_pkg::CharW-1:0]         ascii_char,
  output logic                               last_char
);

  logic              up_ready;
  logic              mid_valid;
  logic              mid_ready;
  sida_pkg::digits_t mid_item;

  assign value_stall = !up_ready;

  sida_bcd_pipe u_bcd_pipe (
    .clk      (clk),
    .rst      (rst),
    .up_valid (value_valid),
    .up_ready (up_ready),
    .value    (value),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .item     (mid_item)
  );

  sida_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (mid_valid),
    .up_ready   (mid_ready),
    .item       (mid_item),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

  a_char_code: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (ascii_char == sida_pkg::AsciiMinus) ||
                   ((ascii_char >= sida_pkg::AsciiZero) &&
                    (ascii_char <= sida_pkg::AsciiZero + 8'd9)))
    else $error("character outside the minus sign and digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && (ascii_char == sida_pkg::AsciiMinus)) |-> !last_char)
    else $error("minus sign marked as the last character");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !char_valid)
    else $error("character offered straight after reset");

  a_no_minus_after_digit: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_stall && !last_char && (ascii_char != sida_pkg::AsciiMinus))
    |=> !(char_valid && (ascii_char == sida_pkg::AsciiMinus)))
    else $error("minus sign inside a number");

endmodule

[rtl/sida_bcd_pipe.sv]
module sida_bcd_pipe (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  logic signed [sida_pkg::ValueW-1:0] value,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output sida_pkg::digits_t                  item
);

  localparam int LastStage = sida_pkg::NumStages + 1;

  // Stage 0 takes the magnitude, stages 1 to NumStages shift four bits each
  // into the BCD register, and the last stage finds the leading digit.
  logic [LastStage:0]            v;
  logic [LastStage+1:0]          rdy;
  logic [sida_pkg::NumStages:0]  neg;
  logic [sida_pkg::BcdW-1:0]     bcd [sida_pkg::NumStages+1];
  logic [sida_pkg::ValueW-1:0]   bin [sida_pkg::NumStages+1];
  logic [sida_pkg::ValueW-1:0]   mag;

  assign mag = value[sida_pkg::ValueW-1] ? (~value + 1'b1) : value;

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    rdy[LastStage+1] = dn_ready;
    for (int i = LastStage; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= up_valid;
      end
      for (int i = 1; i <= LastStage; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      neg[0] <= value[sida_pkg::ValueW-1];
      bcd[0] <= '0;
      bin[0] <= mag;
    end
    for (int i = 1; i <= sida_pkg::NumStages; i++) begin
      if (rdy[i]) begin
        neg[i] <= neg[i-1];
        bcd[i] <= sida_pkg::dabble_group(bcd[i-1],
                    bin[i-1][sida_pkg::ValueW-1 -: sida_pkg::BitsPerStage]);
        bin[i] <= bin[i-1] << sida_pkg::BitsPerStage;
      end
    end
    if (rdy[LastStage]) begin
      item.neg   <= neg[sida_pkg::NumStages];
      item.bcd   <= bcd[sida_pkg::NumStages];
      item.first <= sida_pkg::first_digit(bcd[sida_pkg::NumStages]);
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v[LastStage];

endmodule

[rtl/sida_serial.sv]
module sida_serial (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  sida_pkg::digits_t            item,
  output logic                         char_valid,
  input  logic                         char_stall,
  output logic [sida_pkg::CharW-1:0]   ascii_char,
  output logic                         last_char
);

  sida_pkg::digits_t           cur;
  logic                        cur_v;
  logic                        sign_pend;
  logic [sida_pkg::IdxW-1:0]   idx;
  logic                        load_out;
  logic                        issue;
  logic                        is_last;
  logic                        done;
  logic                        take;
  logic [sida_pkg::CharW-1:0]  char_next;

  assign load_out = !char_valid || !char_stall;
  assign issue    = cur_v && load_out;
  assign is_last  = !sign_pend && (idx == sida_pkg::LastIdx);
  assign done     = issue && is_last;
  // The next number is taken in the cycle its predecessor's last character
  // goes out, so numbers follow each other without a gap.
  assign up_ready = !cur_v || done;
  assign take     = up_valid && up_ready;

  assign char_next = sign_pend ? sida_pkg::AsciiMinus
                               : sida_pkg::AsciiZero +
                                 {4'b0000, sida_pkg::digit_at(cur.bcd, idx)};

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v      <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      if (load_out) begin
        char_valid <= cur_v;
      end
      if (take) begin
        cur_v <= 1'b1;
      end else if (done) begin
        cur_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ascii_char <= char_next;
      last_char  <= is_last;
    end
    if (take) begin
      cur       <= item;
      sign_pend <= item.neg;
      idx       <= item.first;
    end else if (issue) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule
